// File: sv/pcc_pkg.sv
// shared types, constants and codes for the clamped pid controller
// no dependencies; imported by every module of the block
`default_nettype none

package pcc_pkg;

   // field widths are fixed by the interface
   localparam int DATA_WIDTH        = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int SUM_WIDTH         = 64;
   localparam int ERR_WIDTH         = DATA_WIDTH + 1;
   localparam int MUL_WIDTH         = DATA_WIDTH + 2;
   localparam int LIMB_WIDTH        = MUL_WIDTH - 1;
   localparam int NUM_LIMBS         = (SUM_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int LIMB_BITS         = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;

   // multiplier issue schedule
   localparam int SLOT_ERR_DT     = 0;
   localparam int SLOT_DELTA_RATE = 1;
   localparam int SLOT_GP_ERR     = 2;
   localparam int GI_SLOT         = 4;
   localparam int GD_SLOT         = GI_SLOT + NUM_LIMBS;
   localparam int NUM_SLOTS       = GD_SLOT + NUM_LIMBS;
   localparam int SLOT_BITS       = $clog2(NUM_SLOTS);
   localparam int DRAIN_CYCLES    = 3;

   // configuration port
   localparam int ADDR_WIDTH    = 5;
   localparam int REG_IDX_BITS  = 3;
   localparam int APB_WIDTH     = 32;

   localparam logic signed [DATA_WIDTH-1:0] GAIN_P_RESET    = 32'sd65536;
   localparam logic signed [DATA_WIDTH-1:0] GAIN_I_RESET    = 32'sd0;
   localparam logic signed [DATA_WIDTH-1:0] GAIN_D_RESET    = 32'sd0;
   localparam logic [DATA_WIDTH-1:0]        STEP_TIME_RESET = 32'd65536;
   localparam logic [DATA_WIDTH-1:0]        STEP_RATE_RESET = 32'd65536;
   localparam logic signed [DATA_WIDTH-1:0] OUT_MAX_RESET   = 32'sh7fff_ffff;
   localparam logic signed [DATA_WIDTH-1:0] OUT_MIN_RESET   = 32'sh8000_0000;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_GAIN_P    = 3'd0,
      REG_GAIN_I    = 3'd1,
      REG_GAIN_D    = 3'd2,
      REG_STEP_TIME = 3'd3,
      REG_STEP_RATE = 3'd4,
      REG_OUT_MAX   = 3'd5,
      REG_OUT_MIN   = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_MAX  = 2'd1,
      CLAMP_MIN  = 2'd2
   } clamp_type;

   typedef enum logic [2:0] {
      OP_ERR_DT     = 3'd0,
      OP_DELTA_RATE = 3'd1,
      OP_GP_ERR     = 3'd2,
      OP_GI_SUM     = 3'd3,
      OP_GD_DERIV   = 3'd4
   } op_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] target;
      logic signed [DATA_WIDTH-1:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] drive;
      clamp_type                    clamp_state;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] gain_p;
      logic signed [DATA_WIDTH-1:0] gain_i;
      logic signed [DATA_WIDTH-1:0] gain_d;
      logic [DATA_WIDTH-1:0]        step_time;
      logic [DATA_WIDTH-1:0]        step_rate;
      logic signed [DATA_WIDTH-1:0] out_max;
      logic signed [DATA_WIDTH-1:0] out_min;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic                 load;
      logic                 delta_take;
      logic                 issue;
      logic                 first;
      logic                 last;
      op_type               op;
      logic [LIMB_BITS-1:0] limb;
      logic                 out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// File: sv/pcc_regs.sv
// configuration register file behind the apb-style port
// depends on pcc_pkg for the register map and reset values
`default_nettype none

module pcc_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pcc_pkg::ADDR_WIDTH-1:0]    paddr,
   input  logic [pcc_pkg::APB_WIDTH-1:0]     pwdata,
   output logic [pcc_pkg::APB_WIDTH-1:0]     prdata,
   output logic                              pready,
   output pcc_pkg::cfg_type                  cfg
);
   import pcc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[ADDR_WIDTH-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_GAIN_P:    cfg_in.gain_p    = pwdata;
            REG_GAIN_I:    cfg_in.gain_i    = pwdata;
            REG_GAIN_D:    cfg_in.gain_d    = pwdata;
            REG_STEP_TIME: cfg_in.step_time = pwdata;
            REG_STEP_RATE: cfg_in.step_rate = pwdata;
            REG_OUT_MAX:   cfg_in.out_max   = pwdata;
            REG_OUT_MIN:   cfg_in.out_min   = pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_GAIN_P:    prdata = cfg_ff.gain_p;
         REG_GAIN_I:    prdata = cfg_ff.gain_i;
         REG_GAIN_D:    prdata = cfg_ff.gain_d;
         REG_STEP_TIME: prdata = cfg_ff.step_time;
         REG_STEP_RATE: prdata = cfg_ff.step_rate;
         REG_OUT_MAX:   prdata = cfg_ff.out_max;
         REG_OUT_MIN:   prdata = cfg_ff.out_min;
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p    <= GAIN_P_RESET;
         cfg_ff.gain_i    <= GAIN_I_RESET;
         cfg_ff.gain_d    <= GAIN_D_RESET;
         cfg_ff.step_time <= STEP_TIME_RESET;
         cfg_ff.step_rate <= STEP_RATE_RESET;
         cfg_ff.out_max   <= OUT_MAX_RESET;
         cfg_ff.out_min   <= OUT_MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/pcc_ctrl.sv
// sequencer: accepts a beat, issues the multiplier schedule, drains, loads the result
// depends on pcc_pkg for the command/status structs and slot constants
`default_nettype none

module pcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pcc_pkg::stat_type  stat,
   output pcc_pkg::cmd_type   cmd
);
   import pcc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [SLOT_BITS-1:0] slot_in;

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               slot_in  = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            case (slot_ff) inside
               SLOT_BITS'(SLOT_ERR_DT): begin
                  cmd.issue      = 1'b1;
                  cmd.first      = 1'b1;
                  cmd.last       = 1'b1;
                  cmd.op         = OP_ERR_DT;
                  cmd.delta_take = 1'b1;
               end
               SLOT_BITS'(SLOT_DELTA_RATE): begin
                  cmd.issue = 1'b1;
                  cmd.first = 1'b1;
                  cmd.last  = 1'b1;
                  cmd.op    = OP_DELTA_RATE;
               end
               SLOT_BITS'(SLOT_GP_ERR): begin
                  cmd.issue = 1'b1;
                  cmd.first = 1'b1;
                  cmd.last  = 1'b1;
                  cmd.op    = OP_GP_ERR;
               end
               [SLOT_BITS'(GI_SLOT):SLOT_BITS'(GD_SLOT - 1)]: begin
                  // integral product, top limb first
                  cmd.issue = 1'b1;
                  cmd.first = (slot_ff == SLOT_BITS'(GI_SLOT));
                  cmd.last  = (slot_ff == SLOT_BITS'(GD_SLOT - 1));
                  cmd.op    = OP_GI_SUM;
                  cmd.limb  = LIMB_BITS'(NUM_LIMBS - 1)
                            - LIMB_BITS'(slot_ff - SLOT_BITS'(GI_SLOT));
               end
               [SLOT_BITS'(GD_SLOT):SLOT_BITS'(NUM_SLOTS - 1)]: begin
                  cmd.issue = 1'b1;
                  cmd.first = (slot_ff == SLOT_BITS'(GD_SLOT));
                  cmd.last  = (slot_ff == SLOT_BITS'(NUM_SLOTS - 1));
                  cmd.op    = OP_GD_DERIV;
                  cmd.limb  = LIMB_BITS'(NUM_LIMBS - 1)
                            - LIMB_BITS'(slot_ff - SLOT_BITS'(GD_SLOT));
               end
               default: begin
                  // bubble: integral write-back lands before its product starts
                  cmd.issue = 1'b0;
               end
            endcase
            if (slot_ff == SLOT_BITS'(NUM_SLOTS - 1)) begin
               slot_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (slot_ff == SLOT_BITS'(DRAIN_CYCLES - 1)) begin
               state_in = ST_OUT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/pcc_dp.sv
// datapath: error registers, shared multiplier, limb accumulator, scaling,
// saturating write-back, clamp and output register; depends on pcc_pkg
`default_nettype none

module pcc_dp #(
   parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  pcc_pkg::req_type  req_item,
   input  logic              rsp_ready,
   input  pcc_pkg::cfg_type  cfg,
   input  pcc_pkg::cmd_type  cmd,
   output pcc_pkg::stat_type stat,
   output logic              rsp_valid,
   output pcc_pkg::rsp_type  rsp_item
);
   import pcc_pkg::*;

   localparam int PROD_WIDTH = 2 * MUL_WIDTH;
   localparam int EXT_WIDTH  = NUM_LIMBS * LIMB_WIDTH + 1;
   localparam int ACC_WIDTH  = SUM_WIDTH + MUL_WIDTH;
   localparam logic signed [SUM_WIDTH-1:0] SAT_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SAT_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic   valid;
      logic   first;
      logic   last;
      op_type op;
   } tag_type;

   // one multiplier-sized limb of a 64-bit value; the top limb carries the sign
   function automatic logic signed [MUL_WIDTH-1:0] limb_of(
      input logic signed [SUM_WIDTH-1:0] x,
      input logic [LIMB_BITS-1:0]        k
   );
      logic signed [EXT_WIDTH-1:0] xe;
      logic signed [MUL_WIDTH-1:0] r;
      xe = EXT_WIDTH'(x);
      r  = '0;
      for (int i = 0; i < NUM_LIMBS; i++) begin
         if (k == LIMB_BITS'(i)) begin
            r = (i == NUM_LIMBS - 1) ? signed'(xe[i*LIMB_WIDTH +: MUL_WIDTH])
                                     : signed'({1'b0, xe[i*LIMB_WIDTH +: LIMB_WIDTH]});
         end
      end
      return r;
   endfunction

   function automatic logic signed [SUM_WIDTH-1:0] sat_add(
      input logic signed [SUM_WIDTH-1:0] a,
      input logic signed [SUM_WIDTH-1:0] b
   );
      logic signed [SUM_WIDTH:0] s;
      s = (SUM_WIDTH+1)'(a) + (SUM_WIDTH+1)'(b);
      if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
         return s[SUM_WIDTH] ? SAT_MIN : SAT_MAX;
      end
      return s[SUM_WIDTH-1:0];
   endfunction

   logic signed [ERR_WIDTH-1:0]  err_ff, err_in;
   logic signed [ERR_WIDTH-1:0]  last_err_ff, last_err_in;
   logic signed [MUL_WIDTH-1:0]  delta_ff, delta_in;
   logic signed [SUM_WIDTH-1:0]  esum_ff, esum_in;
   logic signed [SUM_WIDTH-1:0]  deriv_ff, deriv_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic signed [MUL_WIDTH-1:0]  a_op, b_op;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_in, prod_ext, scaled;
   logic [ACC_WIDTH-SUM_WIDTH:0] upper;
   logic signed [SUM_WIDTH-1:0]  q_ff, q_in;
   tag_type                      pt_ff, pt_in, at_ff, at_in, qt_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   // error capture; the previous error is the state carried between beats
   always_comb begin
      err_in      = err_ff;
      last_err_in = last_err_ff;
      delta_in    = delta_ff;
      if (cmd.load) begin
         err_in      = ERR_WIDTH'(req_item.target) - ERR_WIDTH'(req_item.measured);
         last_err_in = err_ff;
      end
      if (cmd.delta_take) begin
         delta_in = MUL_WIDTH'(err_ff) - MUL_WIDTH'(last_err_ff);
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.op)
         OP_ERR_DT: begin
            a_op = MUL_WIDTH'(err_ff);
            b_op = MUL_WIDTH'(cfg.step_time);
         end
         OP_DELTA_RATE: begin
            a_op = delta_ff;
            b_op = MUL_WIDTH'(cfg.step_rate);
         end
         OP_GP_ERR: begin
            a_op = MUL_WIDTH'(cfg.gain_p);
            b_op = MUL_WIDTH'(err_ff);
         end
         OP_GI_SUM: begin
            a_op = MUL_WIDTH'(cfg.gain_i);
            b_op = limb_of(esum_ff, cmd.limb);
         end
         OP_GD_DERIV: begin
            a_op = MUL_WIDTH'(cfg.gain_d);
            b_op = limb_of(deriv_ff, cmd.limb);
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   assign prod_in     = a_op * b_op;
   assign pt_in.valid = cmd.issue;
   assign pt_in.first = cmd.first;
   assign pt_in.last  = cmd.last;
   assign pt_in.op    = cmd.op;

   // limb accumulation, top limb first; wraps harmlessly since the full product fits
   assign prod_ext = ACC_WIDTH'(prod_ff);
   always_comb begin
      acc_in = acc_ff;
      if (pt_ff.valid) begin
         acc_in = pt_ff.first ? prod_ext : (acc_ff <<< LIMB_WIDTH) + prod_ext;
      end
   end

   assign at_in.valid = pt_ff.valid && pt_ff.last;
   assign at_in.first = 1'b0;
   assign at_in.last  = 1'b0;
   assign at_in.op    = pt_ff.op;

   // floor scaling then saturation to 64 bits
   assign scaled = acc_ff >>> FRAC_BITS;
   assign upper  = scaled[ACC_WIDTH-1:SUM_WIDTH-1];
   always_comb begin
      if ((&upper) || !(|upper)) begin
         q_in = scaled[SUM_WIDTH-1:0];
      end else begin
         q_in = scaled[ACC_WIDTH-1] ? SAT_MIN : SAT_MAX;
      end
   end

   // write-back
   always_comb begin
      esum_in  = esum_ff;
      deriv_in = deriv_ff;
      sum_in   = sum_ff;
      if (qt_ff.valid) begin
         case (qt_ff.op)
            OP_ERR_DT:     esum_in  = sat_add(esum_ff, q_ff);
            OP_DELTA_RATE: deriv_in = q_ff;
            OP_GP_ERR:     sum_in   = q_ff;
            OP_GI_SUM:     sum_in   = sat_add(sum_ff, q_ff);
            OP_GD_DERIV:   sum_in   = sat_add(sum_ff, q_ff);
            default:       sum_in   = sum_ff;
         endcase
      end
   end

   // clamp and output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (sum_ff > SUM_WIDTH'(cfg.out_max)) begin
            rsp_in.drive       = cfg.out_max;
            rsp_in.clamp_state = CLAMP_MAX;
         end else if (sum_ff < SUM_WIDTH'(cfg.out_min)) begin
            rsp_in.drive       = cfg.out_min;
            rsp_in.clamp_state = CLAMP_MIN;
         end else begin
            rsp_in.drive       = sum_ff[DATA_WIDTH-1:0];
            rsp_in.clamp_state = CLAMP_NONE;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff       <= '0;
         last_err_ff  <= '0;
         esum_ff      <= '0;
         pt_ff        <= '0;
         at_ff        <= '0;
         qt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         err_ff       <= err_in;
         last_err_ff  <= last_err_in;
         esum_ff      <= esum_in;
         pt_ff        <= pt_in;
         at_ff        <= at_in;
         qt_ff        <= at_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      deriv_ff <= deriv_in;
      sum_ff   <= sum_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      q_ff     <= q_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

// File: sv/pid_controller_clamped_unit.sv
// discrete pid controller with output clamp, signed fixed point
// top level; uses pcc_pkg, pcc_regs, pcc_ctrl and pcc_dp
// usage:
//   req channel (req_valid/req_ready/req_item) takes one beat holding target and
//   measured. rsp channel (rsp_valid/rsp_ready/rsp_item) returns one beat per
//   request holding the clamped drive and its clamp_state code.
//   gains, step_time, step_rate and the limits sit in an apb-style register file
//   at byte addresses 0x00..0x18; change them only while no request is in flight.
// schedule:
//   one request is in flight at a time. the shared 34x34 multiplier runs
//   NUM_SLOTS = 4 + 2*NUM_LIMBS issue slots (8 at 32-bit data): three single
//   products, one slot for the integral write-back, and two limbs each for the
//   64-bit integral and derivative products. after the drain and the clamp
//   state the result is in the output register, and the next request is taken
//   only once the result has been loaded there.
// reset:
//   integral and previous error clear, registers return to their defaults,
//   no result is pending.
// stall:
//   a waiting result holds in the output register; the next request is still
//   accepted and computed, and waits at the clamp cycle until the register frees.
`default_nettype none

module pid_controller_clamped_unit #(
   parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pcc_pkg::req_type               req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pcc_pkg::rsp_type               rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pcc_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [pcc_pkg::APB_WIDTH-1:0]  pwdata,
   output logic [pcc_pkg::APB_WIDTH-1:0]  prdata,
   output logic                           pready
);
   import pcc_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   pcc_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcc_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_ready (rsp_ready),
      .cfg       (cfg),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // sequencer leaves idle right after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is in flight");

   a_clamp_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.clamp_state == CLAMP_MAX) |-> rsp_item.drive == cfg.out_max)
      else $error("max clamp flag without drive at the upper limit");

   a_clamp_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.clamp_state == CLAMP_MIN) |-> rsp_item.drive == cfg.out_min)
      else $error("min clamp flag without drive at the lower limit");

   a_within_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.clamp_state == CLAMP_NONE)
      |-> (rsp_item.drive <= cfg.out_max) && (rsp_item.drive >= cfg.out_min))
      else $error("unclamped drive outside the limits");

endmodule

`default_nettype wire

// File: tb/tb_pid_controller_clamped_unit.sv
// self-checking testbench for the clamped pid controller: directed and random beats
// predicted bit for bit in fixed point; depends on pcc_pkg and pid_controller_clamped_unit
module tb_pid_controller_clamped_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import pcc_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [31:0] D_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] D_MIN = 32'sh8000_0000;
   // index with no register behind it
   localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 3'd7;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_item;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_item;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_WIDTH-1:0] paddr;
   logic [APB_WIDTH-1:0] pwdata;
   logic [APB_WIDTH-1:0] prdata;
   logic pready;

   // predictor state and settings copy
   cfg_type cfg_shadow;
   logic signed [63:0] integ_acc;
   logic signed [63:0] prev_err;
   rsp_type drive_q[$];

   int errors;
   bit no_idle;
   int hold_left;

   pid_controller_clamped_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30000000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void note_failure(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endfunction

   // floor(a*b / 2^FRAC), saturated to 64 bits
   function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] prod;
      wa = a;
      wb = b;
      prod = (wa * wb) >>> FRAC;
      if (prod[127:63] == {65{prod[127]}}) return prod[63:0];
      return prod[127] ? S64_MIN : S64_MAX;
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] s;
      s = a + b;
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   function automatic rsp_type predict_drive(input req_type item);
      logic signed [63:0] err;
      logic signed [63:0] deriv;
      logic signed [63:0] total;
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      rsp_type r;
      err = $signed(item.target) - $signed(item.measured);
      integ_acc = sat_add64(integ_acc, q_mul(err, {32'd0, cfg_shadow.step_time}));
      deriv = q_mul(err - prev_err, {32'd0, cfg_shadow.step_rate});
      prev_err = err;
      total = q_mul($signed(cfg_shadow.gain_p), err);
      total = sat_add64(total, q_mul($signed(cfg_shadow.gain_i), integ_acc));
      total = sat_add64(total, q_mul($signed(cfg_shadow.gain_d), deriv));
      hi = $signed(cfg_shadow.out_max);
      lo = $signed(cfg_shadow.out_min);
      r.drive = total[31:0];
      r.clamp_state = CLAMP_NONE;
      // upper limit wins when the limits are inverted
      if (total > hi) begin
         r.drive = cfg_shadow.out_max;
         r.clamp_state = CLAMP_MAX;
      end else if (total < lo) begin
         r.drive = cfg_shadow.out_min;
         r.clamp_state = CLAMP_MIN;
      end
      return r;
   endfunction

   function automatic logic [31:0] cfg_word(input logic [REG_IDX_BITS-1:0] idx);
      case (idx)
         REG_GAIN_P:    return cfg_shadow.gain_p;
         REG_GAIN_I:    return cfg_shadow.gain_i;
         REG_GAIN_D:    return cfg_shadow.gain_d;
         REG_STEP_TIME: return cfg_shadow.step_time;
         REG_STEP_RATE: return cfg_shadow.step_rate;
         REG_OUT_MAX:   return cfg_shadow.out_max;
         REG_OUT_MIN:   return cfg_shadow.out_min;
         default:       return '0;
      endcase
   endfunction

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      case (idx)
         REG_GAIN_P:    cfg_shadow.gain_p = value;
         REG_GAIN_I:    cfg_shadow.gain_i = value;
         REG_GAIN_D:    cfg_shadow.gain_d = value;
         REG_STEP_TIME: cfg_shadow.step_time = value;
         REG_STEP_RATE: cfg_shadow.step_rate = value;
         REG_OUT_MAX:   cfg_shadow.out_max = value;
         REG_OUT_MIN:   cfg_shadow.out_min = value;
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic csr_check(input logic [REG_IDX_BITS-1:0] idx);
      logic [31:0] want;
      want = cfg_word(idx);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata !== want)
         note_failure($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic check_settings();
      reg_index_type r;
      r = r.first();
      repeat (r.num()) begin
         csr_check(r);
         r = r.next();
      end
   endtask

   task automatic apply_settings(input cfg_type c);
      csr_write(REG_GAIN_P, c.gain_p);
      csr_write(REG_GAIN_I, c.gain_i);
      csr_write(REG_GAIN_D, c.gain_d);
      csr_write(REG_STEP_TIME, c.step_time);
      csr_write(REG_STEP_RATE, c.step_rate);
      csr_write(REG_OUT_MAX, c.out_max);
      csr_write(REG_OUT_MIN, c.out_min);
      check_settings();
   endtask

   // valid stays high after the beat; the next call or drain_results decides
   task automatic send_item(input logic signed [31:0] target, input logic signed [31:0] measured);
      req_type item;
      item.target = target;
      item.measured = measured;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_item = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      drive_q.push_back(predict_drive(item));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_gain();
      logic signed [31:0] v;
      case ($urandom_range(19))
         0: return D_MAX;
         1: return D_MIN;
         2: return '0;
         3, 4, 5: return $urandom();
         default: begin
            v = $urandom_range(32'h0008_0000);
            return v - 32'sh0004_0000;
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_step();
      case ($urandom_range(19))
         0: return 32'hffff_ffff;
         1: return 32'd1;
         2: return 32'd0;
         3, 4: return $urandom();
         default: return $urandom_range(32'h0004_0000, 32'h0000_1000);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      logic signed [31:0] span;
      c.gain_p = rand_gain();
      c.gain_i = rand_gain();
      c.gain_d = rand_gain();
      c.step_time = rand_step();
      c.step_rate = rand_step();
      case ($urandom_range(5))
         0: begin
            c.out_max = D_MAX;
            c.out_min = D_MIN;
         end
         1: begin
            // inverted limits
            span = $urandom_range(32'h0010_0000);
            c.out_max = -span;
            c.out_min = span;
         end
         2: begin
            c.out_max = $urandom();
            c.out_min = $urandom();
         end
         default: begin
            span = $urandom_range(32'h0400_0000, 1);
            c.out_max = span;
            c.out_min = -span;
         end
      endcase
      return c;
   endfunction

   task automatic send_random_item();
      logic signed [31:0] t;
      logic signed [31:0] m;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            t = $urandom();
            m = $urandom();
         end
         4: begin
            t = $urandom_range(1) ? D_MAX : D_MIN;
            m = $urandom_range(1) ? D_MAX : D_MIN;
         end
         default: begin
            // measured tracks the setpoint closely
            t = $urandom_range(32'h0020_0000);
            t = t - 32'sh0010_0000;
            m = $urandom_range(32'h0000_8000);
            m = t + m - 32'sh0000_4000;
         end
      endcase
      send_item(t, m);
   endtask

   task automatic test_reset_defaults();
      check_settings();
      send_item(0, 0);
      send_item(D_MAX, D_MIN);
      send_item(D_MIN, D_MAX);
      send_item(D_MAX, D_MAX);
      send_item(-1, 0);
      send_item(32'sh0001_0000, 0);
      drain_results();
   endtask

   task automatic test_fraction_rounding();
      apply_settings('{gain_p: 32'sh0000_8000, gain_i: 32'sh0000_4000,
                       gain_d: 32'sh0001_0000, step_time: 32'h0000_8000,
                       step_rate: 32'h0002_0000, out_max: 32'sh0010_0000,
                       out_min: 32'shfff0_0000});
      send_item(32'sh0003_0000, 32'sh0001_0000);
      send_item(-1, 0);
      send_item(32'sh0001_0000, 32'sh0005_0000);
      send_item(32'sh0012_3456, -32'sh0065_4321);
      send_item(-32'sh0020_0000, 32'sh0030_0000);
      send_item(7, 7);
      drain_results();
   endtask

   task automatic test_inverted_limits();
      apply_settings('{gain_p: 32'sh0001_0000, gain_i: 0, gain_d: 0,
                       step_time: 32'h0001_0000, step_rate: 32'h0001_0000,
                       out_max: -32'sh0001_0000, out_min: 32'sh0001_0000});
      send_item(32'sh0002_0000, 0);
      send_item(0, 0);
      send_item(0, 32'sh0002_0000);
      send_item(0, 32'sh0001_0000);
      drain_results();
   endtask

   task automatic test_zero_steps_extreme_gains();
      apply_settings('{gain_p: D_MIN, gain_i: D_MAX, gain_d: D_MIN,
                       step_time: 0, step_rate: 0, out_max: D_MAX, out_min: D_MIN});
      // a write to the unused index must leave every register alone
      csr_write(REG_SPARE, 32'hdead_beef);
      check_settings();
      send_item(D_MAX, D_MIN);
      send_item(D_MIN, D_MAX);
      send_item(0, 0);
      send_item(12345, -678);
      drain_results();
   endtask

   task automatic test_sum_saturation();
      apply_settings('{gain_p: D_MAX, gain_i: D_MAX, gain_d: D_MAX,
                       step_time: 32'hffff_ffff, step_rate: 32'hffff_ffff,
                       out_max: D_MAX, out_min: D_MIN});
      send_item(D_MAX, D_MIN);
      send_item(D_MAX, D_MIN);
      send_item(D_MIN, D_MAX);
      send_item(D_MIN, D_MAX);
      drain_results();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 10; phase++) begin
         apply_settings(random_settings());
         no_idle = (phase == 3);
         for (int n = 0; n < 120; n++) begin
            // receiver backs off while beats keep coming, so the input stalls
            if (phase == 5 && n == 40) hold_left = 300;
            send_random_item();
         end
         drain_results();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_integral_swing();
      no_idle = 1'b1;
      apply_settings('{gain_p: 0, gain_i: 1, gain_d: 0,
                       step_time: 32'hffff_ffff, step_rate: 32'h0000_0001,
                       out_max: D_MAX, out_min: D_MIN});
      // each beat moves the integral by close to 2^48, so both limbs carry weight
      repeat (40) send_item(D_MAX, D_MIN);
      repeat (40) send_item(D_MIN, D_MAX);
      drain_results();
      no_idle = 1'b0;
   endtask

   // result side: random back-pressure plus an optional long hold
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = no_idle || ($urandom_range(99) >= 7);
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_q.size() == 0) begin
            note_failure($sformatf("unexpected result beat: drive %0d clamp %0d",
                                   $signed(rsp_item.drive), rsp_item.clamp_state));
         end else begin
            want = drive_q.pop_front();
            if (rsp_item.drive !== want.drive)
               note_failure($sformatf("drive mismatch: expected %0d got %0d",
                                      $signed(want.drive), $signed(rsp_item.drive)));
            if (rsp_item.clamp_state !== want.clamp_state)
               note_failure($sformatf("clamp_state mismatch: expected %0d got %0d",
                                      want.clamp_state, rsp_item.clamp_state));
         end
      end
   end

   initial begin
      errors = 0;
      no_idle = 1'b0;
      hold_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_shadow = '{gain_p: GAIN_P_RESET, gain_i: GAIN_I_RESET, gain_d: GAIN_D_RESET,
                     step_time: STEP_TIME_RESET, step_rate: STEP_RATE_RESET,
                     out_max: OUT_MAX_RESET, out_min: OUT_MIN_RESET};
      integ_acc = '0;
      prev_err = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_fraction_rounding();
      test_inverted_limits();
      test_zero_steps_extreme_gains();
      test_sum_saturation();
      test_random_settings();
      test_integral_swing();

      // let any stray beat show up past the block's latency
      repeat (30) @(posedge clock);
      if (drive_q.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", drive_q.size()));
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
